>>> hw/rtl/amdfs_pkg.sv
// Shared types, codes and constants for the adjacency matrix DFS block
package amdfs_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VERT_W       = $clog2(MAX_VERTICES);
	localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
	localparam int VCOUNT_W     = 5;
	localparam int WEIGHT_W     = 16;

	localparam logic [WEIGHT_W-1:0] NO_EDGE_WEIGHT = 16'hFFFF;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = 5'd16;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [VERT_W-1:0]   row;
		logic [VERT_W-1:0]   col;
		logic [WEIGHT_W-1:0] weight;
		logic [VERT_W-1:0]   start_vertex;
	} in_item_t;

	typedef struct packed {
		logic [VERT_W-1:0] visited_vertex;
		logic              last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_entry;
		logic start;
		logic push;
		logic pop;
		logic emit_mid;
		logic emit_last;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic found;
		logic depth_one;
		logic slot_free;
	} status_t;

endpackage

>>> hw/rtl/amdfs_dp.sv
// Datapath: adjacency rows, visited flags, vertex stack, output word register
module amdfs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [amdfs_pkg::VCOUNT_W-1:0]     cfg_wdata,
	input  amdfs_pkg::in_item_t                in_data,
	input  amdfs_pkg::cmd_t                    cmd,
	output amdfs_pkg::status_t                 status,
	output logic                               out_valid,
	input  logic                               out_stall,
	output amdfs_pkg::out_item_t               out_data
);

	logic [amdfs_pkg::MAX_VERTICES-1:0] adj_q [amdfs_pkg::MAX_VERTICES];
	logic [amdfs_pkg::VERT_W-1:0]       stack_q [amdfs_pkg::MAX_VERTICES];
	logic [amdfs_pkg::MAX_VERTICES-1:0] visited_q;
	logic [amdfs_pkg::DEPTH_W-1:0]      depth_q;
	logic [amdfs_pkg::VCOUNT_W-1:0]     vcount_q;
	logic [amdfs_pkg::VERT_W-1:0]       pending_q;
	logic                               out_valid_q;
	amdfs_pkg::out_item_t               out_q;

	logic [amdfs_pkg::VCOUNT_W-1:0]     count_use;
	logic [amdfs_pkg::MAX_VERTICES-1:0] scan_mask;
	logic [amdfs_pkg::VERT_W-1:0]       top_idx;
	logic [amdfs_pkg::VERT_W-1:0]       top_vertex;
	logic [amdfs_pkg::MAX_VERTICES-1:0] cand;
	logic [amdfs_pkg::VERT_W-1:0]       next_vertex;
	logic                               slot_free;

	// Clamp the vertex count and build the neighbor scan mask
	always_comb begin
		if (vcount_q > amdfs_pkg::VCOUNT_W'(amdfs_pkg::MAX_VERTICES)) begin
			count_use = amdfs_pkg::VCOUNT_W'(amdfs_pkg::MAX_VERTICES);
		end else begin
			count_use = vcount_q;
		end
		for (int i = 0; i < amdfs_pkg::MAX_VERTICES; i++) begin
			scan_mask[i] = (amdfs_pkg::VCOUNT_W'(i) < count_use);
		end
	end

	// Pick the lowest unvisited neighbor of the vertex on top of the stack
	assign top_idx    = amdfs_pkg::VERT_W'(depth_q - amdfs_pkg::DEPTH_W'(1));
	assign top_vertex = stack_q[top_idx];
	assign cand       = adj_q[top_vertex] & ~visited_q & scan_mask;

	always_comb begin
		next_vertex = '0;
		for (int i = amdfs_pkg::MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				next_vertex = amdfs_pkg::VERT_W'(i);
			end
		end
	end

	assign slot_free        = !out_valid_q || !out_stall;
	assign status.found     = |cand;
	assign status.depth_one = (depth_q == amdfs_pkg::DEPTH_W'(1));
	assign status.slot_free = slot_free;

	// Hold the vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= amdfs_pkg::VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Write one presence bit of the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amdfs_pkg::MAX_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.load_entry) begin
			adj_q[in_data.row][in_data.col] <= (in_data.weight != amdfs_pkg::NO_EDGE_WEIGHT);
		end
	end

	// Advance visited flags and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
		end else if (cmd.start) begin
			visited_q <= amdfs_pkg::MAX_VERTICES'(1) << in_data.start_vertex;
			depth_q   <= amdfs_pkg::DEPTH_W'(1);
		end else if (cmd.push) begin
			visited_q[next_vertex] <= 1'b1;
			depth_q <= depth_q + amdfs_pkg::DEPTH_W'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_q - amdfs_pkg::DEPTH_W'(1);
		end
	end

	// Push onto the stack and keep the newest visited vertex pending
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stack_q[0] <= in_data.start_vertex;
			pending_q  <= in_data.start_vertex;
		end else if (cmd.push) begin
			stack_q[amdfs_pkg::VERT_W'(depth_q)] <= next_vertex;
			pending_q <= next_vertex;
		end
	end

	// Hold the output word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_mid || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_mid || cmd.emit_last) begin
			out_q.visited_vertex <= pending_q;
			out_q.last           <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_mid || cmd.emit_last) |-> slot_free)
		else $error("word emitted into a stalled output register");
	a_push_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !visited_q[next_vertex])
		else $error("pushed vertex already visited");
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= amdfs_pkg::DEPTH_W'(amdfs_pkg::MAX_VERTICES))
		else $error("stack depth overflow");
	a_start_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (depth_q == amdfs_pkg::DEPTH_W'(1)))
		else $error("start did not seed the stack");
`endif

endmodule

>>> hw/rtl/amdfs_ctrl.sv
// Controller: sequences matrix loads and the stack walk of one traversal
module amdfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_mode,
	output logic               in_stall,
	input  amdfs_pkg::status_t status,
	output amdfs_pkg::cmd_t    cmd
);

	amdfs_pkg::state_t state_q;
	amdfs_pkg::state_t state_next;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			amdfs_pkg::ST_IDLE: begin
				if (in_valid && in_mode == amdfs_pkg::MODE_START) begin
					state_next = amdfs_pkg::ST_WALK;
				end
			end
			amdfs_pkg::ST_WALK: begin
				if (!status.found && status.depth_one) begin
					state_next = amdfs_pkg::ST_FLUSH;
				end
			end
			amdfs_pkg::ST_FLUSH: begin
				if (status.slot_free) begin
					state_next = amdfs_pkg::ST_IDLE;
				end
			end
			default: state_next = amdfs_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			amdfs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start      = (in_mode == amdfs_pkg::MODE_START);
					cmd.load_entry = (in_mode == amdfs_pkg::MODE_LOAD);
				end
			end
			amdfs_pkg::ST_WALK: begin
				if (status.found) begin
					// wait for the output slot before visiting the next vertex
					cmd.push     = status.slot_free;
					cmd.emit_mid = status.slot_free;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			amdfs_pkg::ST_FLUSH: begin
				cmd.emit_last = status.slot_free;
			end
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amdfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

`ifndef SYNTHESIS
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in the same cycle");
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amdfs_pkg::ST_WALK && !status.found && status.depth_one)
		|=> state_q == amdfs_pkg::ST_FLUSH)
		else $error("walk end did not flush the last vertex");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amdfs_pkg::ST_IDLE) |-> !(cmd.push || cmd.pop || cmd.emit_mid
		|| cmd.emit_last))
		else $error("stack activity while idle");
`endif

endmodule

>>> hw/rtl/adjacency_matrix_dfs_order.sv
// Top level: depth-first traversal over an internal adjacency matrix
//
//   channel   dir   handshake                 payload
//   in        in    in_valid / in_stall       in_data  (mode, row, col, weight, start_vertex)
//   out       out   out_valid / out_stall     out_data (visited_vertex, last)
//   cfg       in    cfg_we                    cfg_wdata (vertex_count)
//
// A load word writes one matrix bit when taken. A start word that visits k vertices
// is taken, then the stack walk does one row scan per cycle (k-1 pushes of the lowest
// unvisited neighbor, k pops), and a final step sends the last vertex.
// A push, and the final send, wait while the output word is held under stall.
// Reset clears the matrix, flags and depth at once; no clearing pass is needed.
module adjacency_matrix_dfs_order (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [amdfs_pkg::VCOUNT_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  amdfs_pkg::in_item_t            in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output amdfs_pkg::out_item_t           out_data
);

	amdfs_pkg::cmd_t    cmd;
	amdfs_pkg::status_t status;

	amdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	amdfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
